@@ rtl/alc_pkg.sv @@
// Shared opcodes, status codes, controller states and store control for the array list.
package alc_pkg;

  typedef enum logic [2:0] {
    OP_FIRST  = 3'd0,
    OP_NEXT   = 3'd1,
    OP_APPEND = 3'd2,
    OP_REMOVE = 3'd3,
    OP_INSERT = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_END   = 3'd1,
    ST_FULL  = 3'd2,
    ST_INDEX = 3'd3,
    ST_NOCUR = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_RESP
  } state_t;

  // Requests from the controller to the element store
  typedef struct packed {
    logic rd;      // read one entry
    logic wr;      // write one entry
    logic shift;   // start a block move
    logic ascend;  // move towards higher addresses as the walk proceeds (remove)
  } store_ctl_t;

endpackage

@@ rtl/alc_if.sv @@
// Request and response channel interfaces of the array list.
interface alc_req_if #(
  parameter int CNT_W = 7
);
  logic             valid;
  logic             ready;
  logic [2:0]       opcode;
  logic [31:0]      data_in;
  logic [CNT_W-1:0] position;

  modport source (output valid, output opcode, output data_in, output position, input ready);
  modport sink   (input valid, input opcode, input data_in, input position, output ready);
endinterface

interface alc_rsp_if #(
  parameter int CNT_W = 7
);
  logic             valid;
  logic             ready;
  logic [31:0]      data_out;
  logic [2:0]       status;
  logic [CNT_W-1:0] element_count;

  modport source (output valid, output data_out, output status, output element_count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input element_count,
                  output ready);
endinterface

@@ rtl/alc_store.sv @@
// Element memory with a pipelined block-move engine for list shifts.
module alc_store #(
  parameter int CAPACITY = 64,
  parameter int STORE_W  = 32,
  localparam int IDX_W   = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  alc_pkg::store_ctl_t ctl,
  input  logic [IDX_W-1:0]    rd_addr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [STORE_W-1:0]  wr_data,
  input  logic [IDX_W-1:0]    sh_src,
  input  logic [IDX_W-1:0]    sh_dst,
  input  logic [CNT_W-1:0]    sh_len,
  output logic [STORE_W-1:0]  rd_data,
  output logic                busy
);

  logic [STORE_W-1:0] mem [CAPACITY];

  logic [IDX_W-1:0]   src;
  logic [IDX_W-1:0]   dst;
  logic [IDX_W-1:0]   pend_dst;
  logic [CNT_W-1:0]   left;
  logic               pend;
  logic               ascend;

  logic               sh_rd;
  logic               mem_re;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_ra;
  logic [IDX_W-1:0]   mem_wa;
  logic [STORE_W-1:0] mem_wd;

  // Engine control: one read per cycle, its write lands in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
    end else if (ctl.shift) begin
      left <= sh_len;
      pend <= 1'b0;
    end else begin
      pend <= sh_rd;
      if (sh_rd) begin
        left <= left - CNT_W'(1);
      end
    end
  end

  // Engine addresses: advance source and destination together
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      src    <= sh_src;
      dst    <= sh_dst;
      ascend <= ctl.ascend;
    end else if (sh_rd) begin
      src      <= ascend ? src + IDX_W'(1) : src - IDX_W'(1);
      dst      <= ascend ? dst + IDX_W'(1) : dst - IDX_W'(1);
      pend_dst <= dst;
    end
  end

  assign sh_rd = (left != '0);
  assign busy  = sh_rd || pend;

  // Port arbitration: the engine owns the ports while it runs
  assign mem_re = sh_rd || ctl.rd;
  assign mem_ra = sh_rd ? src : rd_addr;
  assign mem_we = pend || ctl.wr;
  assign mem_wa = pend ? pend_dst : wr_addr;
  assign mem_wd = pend ? rd_data : wr_data;

  // Single-port-write, single-port-read memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

endmodule

@@ rtl/array_list_with_cursor.sv @@
// The move walks one entry a cycle through the memory's single read and write port.
// One request is worked on at a time; a new one is taken only after the last is done,
// and a finished result waits in the output register while the next one is worked on.
// Reset empties the list and clears the cursor; the element memory is not cleared.
module array_list_with_cursor #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  alc_req_if.sink        req,
  alc_rsp_if.source      rsp
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int STORE_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  alc_pkg::state_t     state;
  alc_pkg::state_t     state_next;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cur_p1;        // cursor plus one, zero means no position
  logic [CNT_W-1:0]    cur_next;

  logic [2:0]          op_q;
  logic [STORE_W-1:0]  din_q;
  logic [CNT_W-1:0]    pos_q;
  logic [31:0]         res_data;
  logic [31:0]         res_data_next;
  logic [2:0]          res_status;
  logic [2:0]          res_status_next;

  logic                out_valid;
  logic [31:0]         out_data;
  logic [2:0]          out_status;
  logic [CNT_W-1:0]    out_count;
  logic                load_out;

  logic                acc;
  logic                is_empty;
  logic                is_full;
  logic                at_end;
  logic                no_cur;
  logic                pos_bad;

  alc_pkg::store_ctl_t ctl;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic [STORE_W-1:0]  wr_data;
  logic [IDX_W-1:0]    sh_src;
  logic [IDX_W-1:0]    sh_dst;
  logic [CNT_W-1:0]    sh_len;
  logic [STORE_W-1:0]  rd_data;
  logic                busy;

  alc_store #(
    .CAPACITY (CAPACITY),
    .STORE_W  (STORE_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .sh_src  (sh_src),
    .sh_dst  (sh_dst),
    .sh_len  (sh_len),
    .rd_data (rd_data),
    .busy    (busy)
  );

  // Request conditions
  assign req.ready = (state == alc_pkg::S_IDLE);
  assign acc       = req.valid && req.ready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign at_end    = (cur_p1 >= count);
  assign no_cur    = (cur_p1 == '0);
  assign pos_bad   = (req.position > count);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      alc_pkg::S_IDLE: begin
        if (acc) begin
          case (req.opcode)
            alc_pkg::OP_FIRST:  state_next = is_empty ? alc_pkg::S_RESP : alc_pkg::S_FETCH;
            alc_pkg::OP_NEXT:   state_next = at_end ? alc_pkg::S_RESP : alc_pkg::S_FETCH;
            alc_pkg::OP_REMOVE: state_next = no_cur ? alc_pkg::S_RESP : alc_pkg::S_FETCH;
            alc_pkg::OP_INSERT: begin
              state_next = (is_full || pos_bad) ? alc_pkg::S_RESP : alc_pkg::S_SHIFT;
            end
            default:            state_next = alc_pkg::S_RESP;
          endcase
        end
      end
      alc_pkg::S_FETCH: begin
        state_next = (op_q == alc_pkg::OP_REMOVE) ? alc_pkg::S_SHIFT : alc_pkg::S_RESP;
      end
      alc_pkg::S_SHIFT: begin
        if (!busy) begin
          state_next = alc_pkg::S_RESP;
        end
      end
      alc_pkg::S_RESP: begin
        if (!out_valid || rsp.ready) begin
          state_next = alc_pkg::S_IDLE;
        end
      end
      default: state_next = alc_pkg::S_IDLE;
    endcase
  end

  // State outputs: memory requests, list bookkeeping and result fields
  always_comb begin
    ctl             = '0;
    rd_addr         = '0;
    wr_addr         = '0;
    wr_data         = '0;
    sh_src          = '0;
    sh_dst          = '0;
    sh_len          = '0;
    count_next      = count;
    cur_next        = cur_p1;
    res_data_next   = res_data;
    res_status_next = res_status;
    load_out        = 1'b0;
    unique case (state)
      alc_pkg::S_IDLE: begin
        if (acc) begin
          res_data_next   = '0;
          res_status_next = alc_pkg::ST_OK;
          case (req.opcode)
            alc_pkg::OP_FIRST: begin
              if (is_empty) begin
                res_status_next = alc_pkg::ST_END;
              end else begin
                ctl.rd   = 1'b1;
                rd_addr  = '0;
                cur_next = CNT_W'(1);
              end
            end
            alc_pkg::OP_NEXT: begin
              if (at_end) begin
                res_status_next = alc_pkg::ST_END;
              end else begin
                ctl.rd   = 1'b1;
                rd_addr  = IDX_W'(cur_p1);
                cur_next = cur_p1 + CNT_W'(1);
              end
            end
            alc_pkg::OP_APPEND: begin
              if (is_full) begin
                res_status_next = alc_pkg::ST_FULL;
              end else begin
                ctl.wr     = 1'b1;
                wr_addr    = IDX_W'(count);
                wr_data    = STORE_W'(req.data_in);
                cur_next   = cur_p1 + CNT_W'(1);
                count_next = count + CNT_W'(1);
              end
            end
            alc_pkg::OP_REMOVE: begin
              if (no_cur) begin
                res_status_next = alc_pkg::ST_NOCUR;
              end else begin
                ctl.rd     = 1'b1;
                rd_addr    = IDX_W'(cur_p1 - CNT_W'(1));
                cur_next   = cur_p1 - CNT_W'(1);
                count_next = count - CNT_W'(1);
              end
            end
            alc_pkg::OP_INSERT: begin
              if (is_full) begin
                res_status_next = alc_pkg::ST_FULL;
              end else if (pos_bad) begin
                res_status_next = alc_pkg::ST_INDEX;
              end else begin
                // Move the tail up by one, walking down from the end
                ctl.shift  = 1'b1;
                ctl.ascend = 1'b0;
                sh_dst     = IDX_W'(count);
                sh_src     = IDX_W'(count - CNT_W'(1));
                sh_len     = count - req.position;
                count_next = count + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      alc_pkg::S_FETCH: begin
        res_data_next = 32'(rd_data);
        if (op_q == alc_pkg::OP_REMOVE) begin
          // Close the gap: bookkeeping already holds the post-remove values
          ctl.shift  = 1'b1;
          ctl.ascend = 1'b1;
          sh_dst     = IDX_W'(cur_p1);
          sh_src     = IDX_W'(cur_p1 + CNT_W'(1));
          sh_len     = count - cur_p1;
        end
      end
      alc_pkg::S_SHIFT: begin
        if (!busy && op_q == alc_pkg::OP_INSERT) begin
          ctl.wr  = 1'b1;
          wr_addr = IDX_W'(pos_q);
          wr_data = din_q;
        end
      end
      alc_pkg::S_RESP: begin
        load_out = !out_valid || rsp.ready;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alc_pkg::S_IDLE;
      count     <= '0;
      cur_p1    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cur_p1 <= cur_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the request and build the result
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q  <= req.opcode;
      din_q <= STORE_W'(req.data_in);
      pos_q <= req.position;
    end
    res_data   <= res_data_next;
    res_status <= res_status_next;
    if (load_out) begin
      out_data   <= res_data;
      out_status <= res_status;
      out_count  <= count;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.data_out      = out_data;
  assign rsp.status        = out_status;
  assign rsp.element_count = out_count;

  // The cursor never points past the last element
  assert property (@(posedge clk) disable iff (rst) cur_p1 <= count)
    else $error("cursor beyond element count");

  // A new request is only taken once the move engine has drained
  assert property (@(posedge clk) disable iff (rst) state == alc_pkg::S_IDLE |-> !busy)
    else $error("store busy while idle");

  // An accepted append on a non-full list grows the list by one
  assert property (@(posedge clk) disable iff (rst)
    (acc && req.opcode == alc_pkg::OP_APPEND && !is_full)
      |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the list");

endmodule
